// File: rtl/altok_pkg.sv
// Shared types, character codes and class helpers for the assembly line tokenizer.
// Depends on nothing; imported by the buffer, the tokenizer core and the bench.
package altok_pkg;

  localparam int TOKEN_LEN_DEFAULT = 32;
  localparam int LEN_W             = 6;
  localparam int KIND_W            = 3;

  localparam logic [1:0] MODE_DEFAULT  = 2'd0;
  localparam logic [1:0] MODE_REGISTER = 2'd1;
  localparam logic [1:0] MODE_ARGUMENT = 2'd2;

  localparam logic [KIND_W-1:0] KIND_LABEL    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_KEYWORD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REGISTER = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INTEGER  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TARGET   = 3'd4;

  localparam logic [7:0] CH_DIGIT_LO = 8'd48;
  localparam logic [7:0] CH_DIGIT_HI = 8'd57;
  localparam logic [7:0] CH_UPPER_LO = 8'd65;
  localparam logic [7:0] CH_UPPER_HI = 8'd90;
  localparam logic [7:0] CH_LOWER_LO = 8'd97;
  localparam logic [7:0] CH_LOWER_HI = 8'd122;
  localparam logic [7:0] CH_SPACE    = 8'd32;
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_NEWLINE  = 8'd10;
  localparam logic [7:0] CH_COLON    = 8'd58;
  localparam logic [7:0] CH_DOLLAR   = 8'd36;
  localparam logic [7:0] CH_COMMA    = 8'd44;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } char_word_t;

  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    logic [7:0]        token_char;
    logic              char_valid;
    logic [LEN_W-1:0]  token_length;
    logic              token_overflow;
    logic              last_of_token;
  } token_word_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_DIGIT_LO) && (c <= CH_DIGIT_HI);
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_digit(c) || ((c >= CH_UPPER_LO) && (c <= CH_UPPER_HI)) ||
           ((c >= CH_LOWER_LO) && (c <= CH_LOWER_HI));
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
  endfunction

endpackage

// File: rtl/altok_buffer.sv
// Token character buffer: one write port, one read port, registered read data.
// Depends on altok_pkg for the default depth.
module altok_buffer
  import altok_pkg::*;
#(
  parameter int DEPTH  = TOKEN_LEN_DEFAULT,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/assembly_line_tokenizer_core.sv
// Assembly line tokenizer core: mode tracking, token store and readout sequencer.
// Depends on altok_pkg and altok_buffer.
//
// Takes one character word per accepted handshake and splits the stream into
// tokens (label, keyword, register, integer, target). Characters of the
// pending token sit in a small synchronous buffer. A character that does not
// close a token is taken without stalling intake. When a token closes, intake
// stalls and the token is read out of the buffer one character per result
// word, each by a buffer read, then an output register load that waits while
// the output is held downstream. The single read port and registered data
// keep the readout to one character at a time; an empty token gives one word.
// The output register lets the next character be taken while the last result
// word waits downstream. Characters past MAX_TOKEN_LEN are dropped, flagged.
module assembly_line_tokenizer_core
  import altok_pkg::*;
#(
  parameter int MAX_TOKEN_LEN = TOKEN_LEN_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  char_word_t  chars,
  input  logic        chars_valid,
  output logic        chars_stall,
  output token_word_t tokens,
  output logic        tokens_valid,
  input  logic        tokens_stall
);

  localparam int CW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int AW = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_TOKEN_LEN);

  localparam logic [1:0] ST_IDLE  = 2'd0;  // taking characters
  localparam logic [1:0] ST_READ  = 2'd1;  // issue buffer read
  localparam logic [1:0] ST_WAIT  = 2'd2;  // buffer data ready, load output
  localparam logic [1:0] ST_EMPTY = 2'd3;  // empty token result

  logic [1:0]        state, state_next;
  logic [1:0]        mode, mode_next;
  logic [CW-1:0]     count;
  logic              dropped;
  logic              first_digit;

  // latched token being emitted
  logic [KIND_W-1:0] emit_kind;
  logic [CW-1:0]     emit_len;
  logic              emit_ovf;
  logic [CW-1:0]     rd_idx;

  token_word_t       out_q;
  logic              out_valid;

  // step decode
  logic              accept;
  logic [7:0]        c;
  logic              c_alnum, c_space, c_digit;
  logic              store, emit;
  logic              do_write;
  logic [KIND_W-1:0] kind;
  logic [CW-1:0]     cnt_st;
  logic              drop_st;
  logic              first_st;

  logic [7:0]        rd_data;
  logic              out_free;
  logic [CW-1:0]     rd_idx_inc;
  logic              read_last;

  assign accept   = chars_valid && !chars_stall;
  assign c        = chars.char_code;
  assign c_alnum  = is_alnum(c);
  assign c_space  = is_space(c);
  assign c_digit  = is_digit(c);
  assign out_free = !out_valid || !tokens_stall;

  assign rd_idx_inc = rd_idx + CW'(1);
  assign read_last  = (rd_idx_inc == emit_len);

  always_comb begin
    store     = 1'b0;
    emit      = 1'b0;
    kind      = KIND_KEYWORD;
    mode_next = mode;
    unique case (mode)
      MODE_REGISTER: begin
        if (c_alnum) begin
          store = 1'b1;
        end else if (c_space || (c == CH_COMMA)) begin
          emit      = 1'b1;
          kind      = KIND_REGISTER;
          mode_next = (c == CH_COMMA) ? MODE_ARGUMENT : MODE_DEFAULT;
        end
      end
      MODE_ARGUMENT: begin
        if (c_alnum) begin
          store = 1'b1;
        end else if (c == CH_DOLLAR) begin
          mode_next = MODE_REGISTER;
        end else if (c_space && (count != '0)) begin
          emit      = 1'b1;
          kind      = KIND_INTEGER;
          mode_next = MODE_DEFAULT;
        end
      end
      default: begin
        // the unused mode code behaves as default mode
        mode_next = MODE_DEFAULT;
        if (c_alnum) begin
          store = 1'b1;
        end else if (c == CH_COLON) begin
          emit = 1'b1;
          kind = KIND_LABEL;
        end else if (c_space && (count != '0)) begin
          emit = 1'b1;
          kind = KIND_KEYWORD;
        end else if (c == CH_DOLLAR) begin
          mode_next = MODE_REGISTER;
        end
      end
    endcase

    // character store, with overflow drop
    do_write = store && (count < CNT_MAX);
    cnt_st   = do_write ? (count + CW'(1)) : count;
    drop_st  = dropped || (store && !do_write);
    first_st = (do_write && (count == '0)) ? c_digit : first_digit;

    // end-of-line flush, only in default and argument modes
    if (chars.end_of_line && !emit && (cnt_st != '0) && (mode != MODE_REGISTER)) begin
      emit = 1'b1;
      kind = (mode == MODE_ARGUMENT) ? (first_st ? KIND_INTEGER : KIND_TARGET)
                                     : KIND_KEYWORD;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && emit) begin
          state_next = (cnt_st == '0) ? ST_EMPTY : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_free) begin
          state_next = read_last ? ST_IDLE : ST_READ;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      mode        <= MODE_DEFAULT;
      count       <= '0;
      dropped     <= 1'b0;
      first_digit <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        mode        <= mode_next;
        first_digit <= first_st;
        if (emit) begin
          count   <= '0;
          dropped <= 1'b0;
        end else begin
          count   <= cnt_st;
          dropped <= drop_st;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      emit_kind <= kind;
      emit_len  <= cnt_st;
      emit_ovf  <= drop_st;
      rd_idx    <= '0;
    end else if ((state == ST_WAIT) && out_free) begin
      rd_idx <= rd_idx_inc;
    end
  end

  altok_buffer #(
    .DEPTH  (MAX_TOKEN_LEN),
    .ADDR_W (AW)
  ) u_buffer (
    .clk     (clk),
    .wr_en   (accept && do_write),
    .wr_addr (count[AW-1:0]),
    .wr_data (c),
    .rd_en   (state == ST_READ),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (((state == ST_WAIT) || (state == ST_EMPTY)) && out_free) begin
      out_valid <= 1'b1;
    end else if (!tokens_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_WAIT) && out_free) begin
      out_q.token_kind     <= emit_kind;
      out_q.token_char     <= rd_data;
      out_q.char_valid     <= 1'b1;
      out_q.token_length   <= LEN_W'(emit_len);
      out_q.token_overflow <= emit_ovf;
      out_q.last_of_token  <= read_last;
    end else if ((state == ST_EMPTY) && out_free) begin
      out_q.token_kind     <= emit_kind;
      out_q.token_char     <= 8'd0;
      out_q.char_valid     <= 1'b0;
      out_q.token_length   <= '0;
      out_q.token_overflow <= emit_ovf;
      out_q.last_of_token  <= 1'b1;
    end
  end

  assign chars_stall  = (state != ST_IDLE);
  assign tokens       = out_q;
  assign tokens_valid = out_valid;

`ifndef SYNTH
  // fill count never passes the buffer depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("token count beyond buffer depth");

  // an empty token word is a single closing word of length zero
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    (tokens_valid && !tokens.char_valid) |->
      ((tokens.token_length == '0) && tokens.last_of_token))
    else $error("empty token word malformed");

  // words inside one token keep its kind
  a_kind_steady: assert property (@(posedge clk) disable iff (rst)
    (tokens_valid && !tokens_stall && !tokens.last_of_token) |=>
      (!tokens_valid || (tokens.token_kind == $past(tokens.token_kind))))
    else $error("token kind changed within a token");

  // intake is held while a token is read out
  a_no_intake_in_readout: assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |=> (chars_stall && (out_valid || (state != ST_IDLE) ||
                                           $past(state) == ST_IDLE)))
    else $error("character taken during token readout");
`endif

endmodule

// File: sim/altok_tb_pkg.sv
// Scoreboard for the assembly line tokenizer bench: an untimed model of the
// tokenizer and the queue of token words it predicts.
// Depends on altok_pkg.
package altok_tb_pkg;
  import altok_pkg::*;

  class token_scoreboard;
    int unsigned  capacity;
    logic [1:0]   scan_state;
    logic [7:0]   held_chars [$];
    logic         chars_dropped;
    token_word_t  expected_tokens [$];
    int unsigned  mismatch_count;

    function new(int unsigned cap);
      capacity       = cap;
      scan_state     = MODE_DEFAULT;
      chars_dropped  = 1'b0;
      mismatch_count = 0;
    endfunction

    static function bit digit_ch(logic [7:0] c);
      return c >= CH_DIGIT_LO && c <= CH_DIGIT_HI;
    endfunction

    static function bit word_ch(logic [7:0] c);
      return digit_ch(c) || (c >= CH_UPPER_LO && c <= CH_UPPER_HI) ||
             (c >= CH_LOWER_LO && c <= CH_LOWER_HI);
    endfunction

    static function bit blank_ch(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE;
    endfunction

    function int unsigned pending();
      return expected_tokens.size();
    endfunction

    function void store_char(logic [7:0] c);
      if (held_chars.size() < capacity)
        held_chars.insert(held_chars.size(), c);
      else
        chars_dropped = 1'b1;
    endfunction

    // One word per held character; an empty token still yields one word.
    function void emit_token(logic [KIND_W-1:0] kind);
      token_word_t w;
      int          n;
      n                = held_chars.size();
      w.token_kind     = kind;
      w.token_overflow = chars_dropped;
      if (n == 0) begin
        w.token_char    = '0;
        w.char_valid    = 1'b0;
        w.token_length  = '0;
        w.last_of_token = 1'b1;
        expected_tokens.insert(expected_tokens.size(), w);
      end
      for (int i = 0; i < n; i++) begin
        w.token_char    = held_chars[i];
        w.char_valid    = 1'b1;
        w.token_length  = LEN_W'(n);
        w.last_of_token = (i == n - 1);
        expected_tokens.insert(expected_tokens.size(), w);
      end
      held_chars.delete();
      chars_dropped = 1'b0;
    endfunction

    // Advance the model by one accepted character word.
    function void note_char(char_word_t word);
      logic [7:0] c;
      c = word.char_code;
      case (scan_state)
        MODE_REGISTER: begin
          if (word_ch(c)) begin
            store_char(c);
          end else if (blank_ch(c) || c == CH_COMMA) begin
            emit_token(KIND_REGISTER);
            scan_state = (c == CH_COMMA) ? MODE_ARGUMENT : MODE_DEFAULT;
          end
        end
        MODE_ARGUMENT: begin
          if (word_ch(c)) begin
            store_char(c);
          end else if (c == CH_DOLLAR) begin
            scan_state = MODE_REGISTER;
          end else if (blank_ch(c) && held_chars.size() != 0) begin
            emit_token(KIND_INTEGER);
            scan_state = MODE_DEFAULT;
          end
          if (word.end_of_line && held_chars.size() != 0)
            emit_token(digit_ch(held_chars[0]) ? KIND_INTEGER : KIND_TARGET);
        end
        default: begin
          scan_state = MODE_DEFAULT;
          if (word_ch(c)) begin
            store_char(c);
          end else if (c == CH_COLON) begin
            emit_token(KIND_LABEL);
          end else if (blank_ch(c)) begin
            if (held_chars.size() != 0)
              emit_token(KIND_KEYWORD);
          end else if (c == CH_DOLLAR) begin
            scan_state = MODE_REGISTER;
          end
          if (word.end_of_line && held_chars.size() != 0)
            emit_token(KIND_KEYWORD);
        end
      endcase
    endfunction

    function string show(token_word_t w);
      return $sformatf("kind %0d char %02h valid %0b len %0d ovf %0b last %0b",
                       w.token_kind, w.token_char, w.char_valid, w.token_length,
                       w.token_overflow, w.last_of_token);
    endfunction

    function void flag_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("ERROR: %s", msg);
    endfunction

    // Compare one accepted token word with the oldest prediction.
    function void check_token(token_word_t got);
      token_word_t want;
      if (expected_tokens.size() == 0) begin
        flag_mismatch($sformatf("token word with nothing expected: %s", show(got)));
        return;
      end
      want = expected_tokens.pop_front();
      if (got.token_kind !== want.token_kind || got.token_char !== want.token_char ||
          got.char_valid !== want.char_valid || got.token_length !== want.token_length ||
          got.token_overflow !== want.token_overflow ||
          got.last_of_token !== want.last_of_token)
        flag_mismatch($sformatf("token word: expected %s, got %s", show(want), show(got)));
    endfunction
  endclass

endpackage

// File: sim/tb_assembly_line_tokenizer_core.sv
// Bench for assembly_line_tokenizer_core: directed and random assembly text,
// random idling on both sides, token words checked against altok_tb_pkg.
// Depends on altok_pkg, altok_tb_pkg and the tokenizer RTL.
module tb_assembly_line_tokenizer_core;
  import altok_pkg::*;
  import altok_tb_pkg::*;

  localparam int TOKEN_CAP     = TOKEN_LEN_DEFAULT;
  localparam int HOLD_CYCLES   = 400;
  // Settle time covers the longest token readout; leave some margin.
  localparam int SETTLE_CYCLES = 2 * TOKEN_CAP + 16;

  logic        clk = 1'b0;
  logic        rst;
  char_word_t  chars;
  logic        chars_valid;
  logic        chars_stall;
  token_word_t tokens;
  logic        tokens_valid;
  logic        tokens_stall;

  logic        hold_off;       // forces the receiver to stall
  int unsigned send_idle_pct;  // chance per cycle that the sender idles
  int unsigned stall_pct;      // chance per cycle that the receiver stalls
  int unsigned words_sent;     // character words accepted so far
  logic [7:0]  line_text [$];  // the line being assembled for sending

  token_scoreboard sb;

  assembly_line_tokenizer_core #(
    .MAX_TOKEN_LEN(TOKEN_CAP)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .chars       (chars),
    .chars_valid (chars_valid),
    .chars_stall (chars_stall),
    .tokens      (tokens),
    .tokens_valid(tokens_valid),
    .tokens_stall(tokens_stall)
  );

  always #5 clk = ~clk;

  // Receiver: check the word taken at this edge, then pick the stall for the
  // next cycle. Reads happen before any NBA of this edge lands, so they see
  // the values the DUT saw.
  always @(posedge clk) begin
    if (!rst && tokens_valid && !tokens_stall)
      sb.check_token(tokens);
    if (rst)
      tokens_stall <= 1'b0;
    else if (hold_off)
      tokens_stall <= 1'b1;
    else
      tokens_stall <= ($urandom_range(99) < stall_pct);
  end

  // Hard stop in case the DUT hangs.
  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Offer one character word, idling first at random, and return at the
  // edge where it is taken. The model is updated at that same edge.
  task automatic send_word(input logic [7:0] code, input logic eol);
    char_word_t w;
    w.char_code   = code;
    w.end_of_line = eol;
    while ($urandom_range(99) < send_idle_pct) begin
      chars_valid <= 1'b0;
      @(posedge clk);
    end
    chars       <= w;
    chars_valid <= 1'b1;
    do @(posedge clk); while (chars_stall);
    sb.note_char(w);
    words_sent++;
  endtask

  task automatic send_str(input string s, input bit eol);
    for (int i = 0; i < s.len(); i++)
      send_word(s[i], eol && (i == s.len() - 1));
  endtask

  // Send the assembled line; end of line rides on its last character.
  task automatic send_text();
    for (int i = 0; i < line_text.size(); i++)
      send_word(line_text[i], i == line_text.size() - 1);
  endtask

  // Sender goes quiet until every predicted word has come out.
  task automatic wait_drained();
    chars_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Receiver held off long enough for the DUT to back up into its input.
  task automatic hold_receiver();
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  function automatic logic [7:0] random_alnum(bit want_digit);
    case (want_digit ? 0 : $urandom_range(2))
      0:       return 8'($urandom_range(CH_DIGIT_LO, CH_DIGIT_HI));
      1:       return 8'($urandom_range(CH_UPPER_LO, CH_UPPER_HI));
      default: return 8'($urandom_range(CH_LOWER_LO, CH_LOWER_HI));
    endcase
  endfunction

  function automatic logic [7:0] random_blank();
    case ($urandom_range(2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_NEWLINE;
    endcase
  endfunction

  // Mostly short tokens, some empty, now and then one past the buffer size.
  function automatic int token_len();
    int r;
    r = $urandom_range(99);
    if (r < 8)
      return $urandom_range(TOKEN_CAP - 2, TOKEN_CAP + 8);
    if (r < 18)
      return 0;
    return $urandom_range(1, 6);
  endfunction

  task automatic push_token(input int len, input bit digit_first);
    for (int i = 0; i < len; i++)
      line_text.insert(line_text.size(), random_alnum(digit_first && i == 0));
  endtask

  // One line of assembly: optional label, mnemonic, then register operands
  // and maybe a trailing argument. Some lines are pure noise, some get a
  // stray character spliced in.
  task automatic send_line();
    int n_ops;
    line_text.delete();
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 4))
        line_text.insert(line_text.size(), 8'($urandom_range(255)));
    end else begin
      if ($urandom_range(99) < 30) begin
        push_token(token_len(), 1'b0);
        line_text.insert(line_text.size(), CH_COLON);
      end
      push_token(token_len(), 1'b0);
      n_ops = $urandom_range(3);
      if (n_ops != 0)
        line_text.insert(line_text.size(), random_blank());
      for (int i = 0; i < n_ops; i++) begin
        if (i < n_ops - 1 || $urandom_range(1) == 0) begin
          line_text.insert(line_text.size(), CH_DOLLAR);
          push_token(token_len(), 1'b0);
          line_text.insert(line_text.size(),
                           (i < n_ops - 1) ? CH_COMMA : random_blank());
        end else begin
          // argument: a closing blank or a leading digit gives an integer, else a target
          push_token(token_len(), $urandom_range(1));
          if ($urandom_range(4) == 0)
            line_text.insert(line_text.size(), random_blank());
        end
      end
      if ($urandom_range(99) < 8)
        line_text.insert($urandom_range(line_text.size()), 8'($urandom_range(255)));
    end
    if (line_text.size() == 0)
      line_text.insert(line_text.size(), random_blank());
    send_text();
  endtask

  task automatic send_lines(input int unsigned quota);
    int unsigned target;
    target = words_sent + quota;
    while (words_sent < target)
      send_line();
  endtask

  initial begin
    sb            = new(TOKEN_CAP);
    send_idle_pct = 0;
    stall_pct     = 0;
    words_sent    = 0;
    rst          <= 1'b1;
    chars        <= '0;
    chars_valid  <= 1'b0;
    tokens_stall <= 1'b0;
    hold_off     <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed text, no idling.
    send_str("Az09:", 1'b0);     // label at the letter and digit extremes
    send_str(":", 1'b0);         // empty label
    send_str("Za\t", 1'b0);      // keyword closed by tab
    send_str("$,", 1'b0);        // empty register, into argument mode
    send_str(" 5", 1'b1);        // blank with nothing held; integer at end of line
    send_str("x\n", 1'b0);       // blank closes argument as integer
    send_str("q$", 1'b0);        // dollar keeps the held q
    send_str("r", 1'b1);         // end of line ignored in register mode
    send_str(" ", 1'b0);         // register "qr"
    send_str("k$", 1'b1);        // end of line flushes keyword after dollar
    send_str(",", 1'b0);         // empty register again
    send_word(8'hFF, 1'b1);      // high code ignored, nothing held
    send_str("$1,$2,b", 1'b1);   // dollar from argument mode; target at end

    // No idling, receiver held off while the sender keeps pushing.
    wait_drained();
    fork
      hold_receiver();
    join_none
    line_text.delete();
    push_token(TOKEN_CAP + 5, 1'b0);  // overflows the buffer
    line_text.insert(line_text.size(), CH_SPACE);
    send_text();
    send_lines(40);

    wait_drained();
    send_idle_pct = 51;
    stall_pct     = 0;
    send_lines(40);

    wait_drained();
    send_idle_pct = 0;
    stall_pct     = 51;
    send_lines(40);

    wait_drained();
    send_idle_pct = 18;
    stall_pct     = 18;
    send_lines(35);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: assembly_line_tokenizer_core.f
rtl/altok_pkg.sv
rtl/altok_buffer.sv
rtl/assembly_line_tokenizer_core.sv
sim/altok_tb_pkg.sv
sim/tb_assembly_line_tokenizer_core.sv
